// ===== rtl/dast_pkg.sv =====
package dast_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MAX_HOUR   = 23;
    localparam int MAX_MINUTE = 59;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ADD    = 3'd1,
        OP_ON     = 3'd2,
        OP_OFF    = 3'd3,
        OP_DELETE = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERWRITE = 2'd1,
        ST_BAD_TIME  = 2'd2,
        ST_BAD_SLOT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [3:0] slot_index;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot_used;
        logic       feed_request;
        logic [7:0] fired_mask;
    } t_out;

    typedef struct packed {
        logic [2:0]        op;
        logic [6:0]        hour;
        logic [6:0]        minute;
        logic [SLOT_W-1:0] idx;
        logic              clr_fired;
    } t_cmd;

    typedef struct packed {
        logic tok;
        logic found;
    } t_link;

    typedef struct packed {
        logic fire;
        logic take;
    } t_stat;

endpackage

// ===== rtl/daily_alarm_slot_table.sv =====
// Daily alarm slot table.
// Input channel: i_in_valid / o_in_stall carry one command or tick in i_in_data.
// Output channel: o_out_valid / i_out_stall carry one result per input item.
// Each slot lives in one cell of a chain; a token walks the chain one cell per
// cycle, so every tick and every valid command visits all SLOT_COUNT cells,
// passing through the scan, fix and done states in turn; rejected commands
// and unused op codes launch no token and go straight to the done state.
// A new item is taken the cycle after the previous one has moved to the output
// register, so the block takes no new item before it is through with the last.
// The output register holds a finished result while the receiver stalls; the
// next item may be taken and worked on meanwhile, and its result then waits
// until the output register frees.
// Reset clears every slot (inactive, unfired, 00:00), the midnight rearm flag,
// the token flags and the output valid flag.
module daily_alarm_slot_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dast_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dast_pkg::t_out o_out_data
);

    localparam int N = dast_pkg::SLOT_COUNT;
    localparam int W = dast_pkg::SLOT_W;

    dast_pkg::t_state r_state, n_state;
    dast_pkg::t_cmd   r_cmd;
    dast_pkg::t_out   r_out;
    logic [1:0]       r_status;
    logic [W-1:0]     r_used;
    logic [W-1:0]     r_pos;
    logic [N-1:0]     r_mask;
    logic             r_launch;
    logic             r_rearm;
    logic             r_out_valid;

    dast_pkg::t_link link [N+1];
    dast_pkg::t_stat stat [N];
    logic [N-1:0]    fire_vec;
    logic [N-1:0]    take_vec;

    logic accept;
    logic time_ok;
    logic idx_ok;
    logic is_slot_op;
    logic midnight;
    logic need_scan;
    logic force0;
    logic load_out;
    logic [1:0] in_status;

    assign link[0].tok   = r_launch;
    assign link[0].found = 1'b0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        dast_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (r_cmd),
            .i_my_index (W'(k)),
            .i_link     (link[k]),
            .i_force    ((k == 0) ? force0 : 1'b0),
            .o_link     (link[k+1]),
            .o_stat     (stat[k])
        );
        assign fire_vec[k] = stat[k].fire;
        assign take_vec[k] = stat[k].take;
    end

    always_comb begin
        time_ok    = (32'(i_in_data.hour) <= dast_pkg::MAX_HOUR) &&
                     (32'(i_in_data.minute) <= dast_pkg::MAX_MINUTE);
        idx_ok     = 32'(i_in_data.slot_index) < N;
        is_slot_op = i_in_data.op inside {dast_pkg::OP_ON, dast_pkg::OP_OFF,
                                          dast_pkg::OP_DELETE};
        midnight   = (i_in_data.hour == '0) && (i_in_data.minute == '0);
        need_scan  = (i_in_data.op == dast_pkg::OP_TICK) ||
                     (i_in_data.op == dast_pkg::OP_CLEAR) ||
                     ((i_in_data.op == dast_pkg::OP_ADD) && time_ok) ||
                     (is_slot_op && idx_ok);
        in_status  = dast_pkg::ST_OK;
        if ((i_in_data.op == dast_pkg::OP_ADD) && !time_ok) begin
            in_status = dast_pkg::ST_BAD_TIME;
        end else if (is_slot_op && !idx_ok) begin
            in_status = dast_pkg::ST_BAD_SLOT;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dast_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = need_scan ? dast_pkg::S_SCAN : dast_pkg::S_DONE;
                end
            end
            dast_pkg::S_SCAN: begin
                if (link[N].tok) begin
                    n_state = dast_pkg::S_FIX;
                end
            end
            dast_pkg::S_FIX: begin
                n_state = dast_pkg::S_DONE;
            end
            dast_pkg::S_DONE: begin
                if (load_out) begin
                    n_state = dast_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dast_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != dast_pkg::S_IDLE);
        accept     = i_in_valid && (r_state == dast_pkg::S_IDLE);
        force0     = (r_state == dast_pkg::S_FIX) && (r_cmd.op == dast_pkg::OP_ADD) &&
                     !link[N].found;
        load_out   = (r_state == dast_pkg::S_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dast_pkg::S_IDLE;
            r_launch    <= 1'b0;
            r_rearm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept && need_scan;
            if (accept && (i_in_data.op == dast_pkg::OP_TICK)) begin
                r_rearm <= midnight;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op        <= i_in_data.op;
            r_cmd.hour      <= i_in_data.hour;
            r_cmd.minute    <= i_in_data.minute;
            r_cmd.idx       <= W'(i_in_data.slot_index);
            r_cmd.clr_fired <= (i_in_data.op == dast_pkg::OP_TICK) && midnight && !r_rearm;
            r_status        <= in_status;
            r_used          <= (is_slot_op && idx_ok) ? W'(i_in_data.slot_index) : '0;
            r_mask          <= '0;
            r_pos           <= '0;
        end else if (r_state == dast_pkg::S_SCAN) begin
            r_pos  <= r_pos + 1'b1;
            r_mask <= r_mask | fire_vec;
            if (|take_vec) begin
                r_used <= r_pos;
            end
        end else if (force0) begin
            r_status <= dast_pkg::ST_OVERWRITE;
            r_used   <= '0;
        end
        if (load_out) begin
            r_out.status       <= r_status;
            r_out.slot_used    <= 3'(r_used);
            r_out.feed_request <= |r_mask;
            r_out.fired_mask   <= 8'(r_mask);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/dast_cell.sv =====
module dast_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dast_pkg::t_cmd              i_cmd,
    input  logic [dast_pkg::SLOT_W-1:0] i_my_index,
    input  dast_pkg::t_link             i_link,
    input  logic                        i_force,
    output dast_pkg::t_link             o_link,
    output dast_pkg::t_stat             o_stat
);

    logic [4:0] r_hour,   n_hour;
    logic [5:0] r_minute, n_minute;
    logic       r_active, n_active;
    logic       r_fired,  n_fired;
    logic       r_tok;
    logic       r_found;
    logic       fired_eff;
    logic       hit;
    logic       sel;

    always_comb begin
        n_hour     = r_hour;
        n_minute   = r_minute;
        n_active   = r_active;
        n_fired    = r_fired;
        o_stat     = '0;
        fired_eff  = r_fired & ~i_cmd.clr_fired;
        hit        = ({2'b00, r_hour} == i_cmd.hour) && ({1'b0, r_minute} == i_cmd.minute);
        sel        = (i_cmd.idx == i_my_index);
        if (i_link.tok) begin
            case (i_cmd.op)
                dast_pkg::OP_TICK: begin
                    o_stat.fire = r_active & ~fired_eff & hit;
                    n_fired     = fired_eff | o_stat.fire;
                end
                dast_pkg::OP_ADD: begin
                    if (!i_link.found && !r_active) begin
                        o_stat.take = 1'b1;
                        n_hour      = i_cmd.hour[4:0];
                        n_minute    = i_cmd.minute[5:0];
                        n_active    = 1'b1;
                        n_fired     = 1'b0;
                    end
                end
                dast_pkg::OP_ON: begin
                    if (sel) begin
                        n_active = 1'b1;
                    end
                end
                dast_pkg::OP_OFF: begin
                    if (sel) begin
                        n_active = 1'b0;
                    end
                end
                dast_pkg::OP_DELETE: begin
                    if (sel) begin
                        n_hour   = '0;
                        n_minute = '0;
                        n_active = 1'b0;
                        n_fired  = 1'b0;
                    end
                end
                dast_pkg::OP_CLEAR: begin
                    n_hour   = '0;
                    n_minute = '0;
                    n_active = 1'b0;
                    n_fired  = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (i_force) begin
            n_hour   = i_cmd.hour[4:0];
            n_minute = i_cmd.minute[5:0];
            n_active = 1'b1;
            n_fired  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour   <= '0;
            r_minute <= '0;
            r_active <= 1'b0;
            r_fired  <= 1'b0;
            r_tok    <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_active <= n_active;
            r_fired  <= n_fired;
            r_tok    <= i_link.tok;
            if (i_link.tok) begin
                r_found <= i_link.found | ~r_active;
            end
        end
    end

    assign o_link.tok   = r_tok;
    assign o_link.found = r_found;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;
    localparam int RAND_PER_PHASE = 550;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int NSLOT          = dast_pkg::SLOT_COUNT;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    dast_pkg::t_in  in_data   = '0;
    logic           out_stall = 1'b0;
    logic           in_stall;
    logic           out_valid;
    dast_pkg::t_out out_data;

    daily_alarm_slot_table DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // alarm table as the block should hold it
    logic [4:0]       alarm_hour [NSLOT];
    logic [5:0]       alarm_min  [NSLOT];
    logic [NSLOT-1:0] alarm_active;
    logic [NSLOT-1:0] fired_today;
    logic             midnight_done;

    dast_pkg::t_out result_q [$];
    dast_pkg::t_in  dir_stim [$];
    bit             dir_known[$];
    dast_pkg::t_out dir_res  [$];

    int   send_idle_pct = 28;
    int   recv_idle_pct = 80;
    bit   long_hold     = 1'b0;
    int   n_err         = 0;
    int   n_sent        = 0;
    int   n_checked     = 0;
    int   n_feeds       = 0;
    int   n_overwrites  = 0;
    int   n_rejects     = 0;
    int   cycle_cnt     = 0;
    dast_pkg::t_out head;

    function automatic void wipe_alarm(int k);
        alarm_hour[k]   = '0;
        alarm_min[k]    = '0;
        alarm_active[k] = 1'b0;
        fired_today[k]  = 1'b0;
    endfunction

    function automatic dast_pkg::t_out predict_alarm(dast_pkg::t_in it);
        dast_pkg::t_out r;
        int   k;
        int   slot;
        int   idx;
        r    = '0;
        slot = -1;
        idx  = int'(it.slot_index);
        case (it.op)
            dast_pkg::OP_TICK: begin
                if (it.hour == '0 && it.minute == '0) begin
                    if (!midnight_done) begin
                        fired_today   = '0;
                        midnight_done = 1'b1;
                    end
                end else begin
                    midnight_done = 1'b0;
                end
                for (k = 0; k < NSLOT; k++) begin
                    if (alarm_active[k] && !fired_today[k] && 7'(alarm_hour[k]) == it.hour &&
                        7'(alarm_min[k]) == it.minute) begin
                        fired_today[k]  = 1'b1;
                        r.feed_request  = 1'b1;
                        r.fired_mask[k] = 1'b1;
                    end
                end
            end
            dast_pkg::OP_ADD: begin
                if (int'(it.hour) > dast_pkg::MAX_HOUR ||
                    int'(it.minute) > dast_pkg::MAX_MINUTE) begin
                    r.status = dast_pkg::ST_BAD_TIME;
                end else begin
                    for (k = 0; k < NSLOT; k++)
                        if (slot < 0 && !alarm_active[k])
                            slot = k;
                    if (slot < 0) begin
                        slot     = 0;
                        r.status = dast_pkg::ST_OVERWRITE;
                    end
                    r.slot_used        = 3'(slot);
                    alarm_hour[slot]   = it.hour[4:0];
                    alarm_min[slot]    = it.minute[5:0];
                    alarm_active[slot] = 1'b1;
                    fired_today[slot]  = 1'b0;
                end
            end
            dast_pkg::OP_ON, dast_pkg::OP_OFF, dast_pkg::OP_DELETE: begin
                if (idx >= NSLOT) begin
                    r.status = dast_pkg::ST_BAD_SLOT;
                end else begin
                    r.slot_used = 3'(idx);
                    if (it.op == dast_pkg::OP_ON)
                        alarm_active[idx] = 1'b1;
                    else if (it.op == dast_pkg::OP_OFF)
                        alarm_active[idx] = 1'b0;
                    else
                        wipe_alarm(idx);
                end
            end
            dast_pkg::OP_CLEAR: begin
                for (k = 0; k < NSLOT; k++)
                    wipe_alarm(k);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic dast_pkg::t_in cmd(logic [2:0] op, int hr, int mn, int idx);
        dast_pkg::t_in c;
        c.op         = op;
        c.hour       = 7'(hr);
        c.minute     = 7'(mn);
        c.slot_index = 4'(idx);
        return c;
    endfunction

    function automatic dast_pkg::t_out rsp(dast_pkg::t_status st, int used, int feed,
                                           int mask);
        dast_pkg::t_out r;
        r.status       = st;
        r.slot_used    = 3'(used);
        r.feed_request = (feed != 0);
        r.fired_mask   = 8'(mask);
        return r;
    endfunction

    task automatic row(dast_pkg::t_in stim, int known, dast_pkg::t_out res);
        dir_stim.push_back(stim);
        dir_known.push_back(known != 0);
        dir_res.push_back(res);
    endtask

    function automatic dast_pkg::t_in random_item();
        dast_pkg::t_in it;
        int  r;
        int  k;
        it.op         = dast_pkg::OP_TICK;
        it.hour       = 7'($urandom_range(99));
        it.minute     = 7'($urandom_range(99));
        it.slot_index = 4'($urandom_range(9));
        k             = $urandom_range(NSLOT - 1);
        r             = $urandom_range(99);
        if (r < 40) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    it.hour   = 7'(alarm_hour[k]);
                    it.minute = 7'(alarm_min[k]);
                end
                5, 6: begin
                    it.hour   = '0;
                    it.minute = '0;
                end
                7, 8: begin
                    it.hour   = 7'($urandom_range(dast_pkg::MAX_HOUR));
                    it.minute = 7'($urandom_range(dast_pkg::MAX_MINUTE));
                end
                default: ;
            endcase
        end else if (r < 62) begin
            it.op = dast_pkg::OP_ADD;
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1))
                    it.hour = 7'($urandom_range(99, dast_pkg::MAX_HOUR + 1));
                else
                    it.minute = 7'($urandom_range(99, dast_pkg::MAX_MINUTE + 1));
            end else if ($urandom_range(3) == 0) begin
                it.hour   = 7'(alarm_hour[k]);
                it.minute = 7'(alarm_min[k]);
            end else begin
                it.hour   = 7'($urandom_range(dast_pkg::MAX_HOUR));
                it.minute = 7'($urandom_range(dast_pkg::MAX_MINUTE));
            end
        end else if (r < 87) begin
            it.op         = (r < 72) ? dast_pkg::OP_ON :
                            (r < 80) ? dast_pkg::OP_OFF : dast_pkg::OP_DELETE;
            it.slot_index = ($urandom_range(9) == 0) ? 4'($urandom_range(9, NSLOT))
                                                     : 4'($urandom_range(NSLOT - 1));
        end else if (r < 89) begin
            it.op = dast_pkg::OP_CLEAR;
        end else begin
            it.op = $urandom_range(1) ? OP_RSVD_A : OP_RSVD_B;
        end
        return it;
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send(dast_pkg::t_in it, bit known, dast_pkg::t_out typed);
        dast_pkg::t_out pred;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(negedge clk); while (in_stall);
        pred = predict_alarm(it);
        result_q.push_back(known ? typed : pred);
        n_sent++;
        @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            n_err++;
        end
    endfunction

    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                n_err++;
            end else begin
                head = result_q.pop_front();
                check_field("status", 8'(head.status), 8'(out_data.status));
                check_field("slot_used", 8'(head.slot_used), 8'(out_data.slot_used));
                check_field("feed_request", 8'(head.feed_request),
                            8'(out_data.feed_request));
                check_field("fired_mask", head.fired_mask, out_data.fired_mask);
                n_checked++;
                if (out_data.feed_request)
                    n_feeds++;
                if (out_data.status == dast_pkg::ST_OVERWRITE)
                    n_overwrites++;
                if (out_data.status == dast_pkg::ST_BAD_TIME ||
                    out_data.status == dast_pkg::ST_BAD_SLOT)
                    n_rejects++;
            end
        end
    end

    initial begin : receiver
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        int            i;
        int            ph;
        int            n;
        dast_pkg::t_in it;
        for (i = 0; i < NSLOT; i++)
            wipe_alarm(i);
        midnight_done = 1'b0;

        row(cmd(dast_pkg::OP_TICK, 0, 0, 0), 1, rsp(dast_pkg::ST_OK, 0, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 23, 59, 0), 1, rsp(dast_pkg::ST_OK, 0, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 24, 0, 0), 1, rsp(dast_pkg::ST_BAD_TIME, 0, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 0, 60, 0), 1, rsp(dast_pkg::ST_BAD_TIME, 0, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 99, 99, 15), 1, rsp(dast_pkg::ST_BAD_TIME, 0, 0, 0));
        row(cmd(dast_pkg::OP_ON, 0, 0, 8), 1, rsp(dast_pkg::ST_BAD_SLOT, 0, 0, 0));
        row(cmd(dast_pkg::OP_OFF, 99, 99, 9), 1, rsp(dast_pkg::ST_BAD_SLOT, 0, 0, 0));
        row(cmd(dast_pkg::OP_DELETE, 0, 0, 8), 1, rsp(dast_pkg::ST_BAD_SLOT, 0, 0, 0));
        row(cmd(OP_RSVD_A, 99, 99, 9), 1, rsp(dast_pkg::ST_OK, 0, 0, 0));
        row(cmd(OP_RSVD_B, 0, 0, 0), 1, rsp(dast_pkg::ST_OK, 0, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 0, 0, 0), 1, rsp(dast_pkg::ST_OK, 1, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 12, 30, 0), 1, rsp(dast_pkg::ST_OK, 2, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 12, 30, 0), 1, rsp(dast_pkg::ST_OK, 3, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 1, 1, 0), 1, rsp(dast_pkg::ST_OK, 4, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 2, 2, 0), 1, rsp(dast_pkg::ST_OK, 5, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 3, 3, 0), 1, rsp(dast_pkg::ST_OK, 6, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 4, 4, 0), 1, rsp(dast_pkg::ST_OK, 7, 0, 0));
        row(cmd(dast_pkg::OP_ADD, 5, 5, 0), 1, rsp(dast_pkg::ST_OVERWRITE, 0, 0, 0));
        row(cmd(dast_pkg::OP_TICK, 12, 30, 0), 0, '0);
        row(cmd(dast_pkg::OP_TICK, 12, 30, 0), 0, '0);
        row(cmd(dast_pkg::OP_TICK, 0, 0, 0), 0, '0);
        row(cmd(dast_pkg::OP_TICK, 0, 0, 0), 0, '0);
        row(cmd(dast_pkg::OP_OFF, 0, 0, 2), 0, '0);
        row(cmd(dast_pkg::OP_ON, 0, 0, 7), 0, '0);
        row(cmd(dast_pkg::OP_DELETE, 0, 0, 3), 0, '0);
        row(cmd(dast_pkg::OP_TICK, 99, 99, 0), 0, '0);
        row(cmd(dast_pkg::OP_CLEAR, 0, 0, 0), 0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_stim.size(); i++)
            send(dir_stim[i], dir_known[i], dir_res[i]);

        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 80 : 0;
            recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 28 : 0;
            // back up the output so the block stalls its input
            if (ph == 2)
                long_hold = 1'b1;
            n = 0;
            while (n < RAND_PER_PHASE) begin
                it = random_item();
                send(it, 1'b0, '0);
                n++;
            end
        end
        in_valid <= 1'b0;

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands and ticks, checked %0d results.", n_sent, n_checked);
        $display("Seen %0d feeding ticks, %0d slot 0 overwrites, %0d rejected commands.",
                 n_feeds, n_overwrites, n_rejects);
        if (n_err == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== daily_alarm_slot_table.f =====
rtl/dast_pkg.sv
rtl/dast_cell.sv
rtl/daily_alarm_slot_table.sv
verif/tb.sv
